// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RAID level classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RLC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

`define RLC_ASSERT_NORST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define RLC_ASSERT(name, clk, rstn, prop)

`define RLC_ASSERT_NORST(name, clk, prop)

`endif

`endif

// File: rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Types, constants and helper functions of the RAID level classifier.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int BYTE_W          = 8;
  localparam int DCNT_W          = 4;
  localparam int CNT_W           = 18;
  localparam int MIS_W           = 10;
  localparam int K_W             = 6;
  localparam int MAX_DISKS_DEF   = 8;
  localparam int BLOCK_BYTES_DEF = 512;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [MIS_W-1:0]  MIS_MAX  = '1;
  localparam logic [DCNT_W-1:0] DCNT_RST = DCNT_W'(2);
  localparam logic [DCNT_W-1:0] DCNT_MIN = DCNT_W'(2);

  typedef enum logic {
    OP_COLUMN = 1'b0,
    OP_DECIDE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_BLOCK   = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    CLS_MIRROR = 2'd0,
    CLS_PARITY = 2'd1,
    CLS_MISS   = 2'd2
  } block_class_e;

  typedef enum logic [1:0] {
    VRD_RAID0      = 2'd0,
    VRD_RAID1      = 2'd1,
    VRD_RAID5_FULL = 2'd2,
    VRD_RAID5_PART = 2'd3
  } verdict_e;

  typedef struct packed {
    logic              differs;
    logic [BYTE_W-1:0] data;
  } lane_res_t;

  typedef struct packed {
    logic         done;
    block_class_e cls;
  } blk_stat_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    verdict_e verdict;
  } dec_stat_t;

  // 100 / (n + 1)
  function automatic logic [K_W-1:0] k_factor(input logic [DCNT_W-1:0] n);
    logic [K_W-1:0] k;
    case (n)
      4'd2:    k = K_W'(33);
      4'd3:    k = K_W'(25);
      4'd4:    k = K_W'(20);
      4'd5:    k = K_W'(16);
      4'd6:    k = K_W'(14);
      4'd7:    k = K_W'(12);
      default: k = K_W'(11);
    endcase
    return k;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/rlc_if.sv
// ----------------------------------------------------------------------------
// rlc_col_if / rlc_res_if
// Valid/ready channels for byte columns in and classification results out.
// ----------------------------------------------------------------------------
interface rlc_col_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] disk0_byte;
  logic [7:0] disk1_byte;
  logic [7:0] disk2_byte;
  logic [7:0] disk3_byte;
  logic [7:0] disk4_byte;
  logic [7:0] disk5_byte;
  logic [7:0] disk6_byte;
  logic [7:0] disk7_byte;
  logic       block_end;

  modport source (
    output valid, op, disk0_byte, disk1_byte, disk2_byte, disk3_byte,
           disk4_byte, disk5_byte, disk6_byte, disk7_byte, block_end,
    input  ready
  );
  modport sink (
    input  valid, op, disk0_byte, disk1_byte, disk2_byte, disk3_byte,
           disk4_byte, disk5_byte, disk6_byte, disk7_byte, block_end,
    output ready
  );
endinterface

interface rlc_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  block_class;
  logic [1:0]  verdict;
  logic [17:0] mirror_total;
  logic [17:0] parity_total;
  logic [17:0] miss_total;

  modport source (
    output valid, result_kind, block_class, verdict, mirror_total,
           parity_total, miss_total,
    input  ready
  );
  modport sink (
    input  valid, result_kind, block_class, verdict, mirror_total,
           parity_total, miss_total,
    output ready
  );
endinterface

// File: rtl/rlc_lane.sv
// ----------------------------------------------------------------------------
// rlc_lane
// One disk lane: compares its byte with disk 0 and gates it for the parity XOR.
// ----------------------------------------------------------------------------
module rlc_lane (
  input  logic [7:0]          ref_i,
  input  logic [7:0]          data_i,
  input  logic                en_i,
  output rlc_pkg::lane_res_t  res_o
);
  import rlc_pkg::*;

  always_comb begin
    res_o.differs = en_i && (data_i != ref_i);
    res_o.data    = en_i ? data_i : '0;
  end

endmodule

// File: rtl/rlc_merge.sv
// ----------------------------------------------------------------------------
// rlc_merge
// Combines lane results, tracks block state and classifies at block end.
// ----------------------------------------------------------------------------
module rlc_merge #(
  parameter int MAX_DISKS   = rlc_pkg::MAX_DISKS_DEF,
  parameter int BLOCK_BYTES = rlc_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                col_i,
  input  logic                end_i,
  input  logic [7:0]          ref_i,
  input  logic [MAX_DISKS-1:1] en_i,
  input  rlc_pkg::lane_res_t  lane_i [MAX_DISKS-1:1],
  output rlc_pkg::blk_stat_t  blk_o
);
  import rlc_pkg::*;

  localparam logic [MIS_W-1:0] THRESH = MIS_W'(BLOCK_BYTES / 100);

  logic [MAX_DISKS-1:1] diff_q, diff_d, diff_new, lane_diff;
  logic [MIS_W-1:0]     mis_q, mis_d, mis_new;
  logic [BYTE_W-1:0]    par;

  always_comb begin
    par = '0;
    for (int j = 1; j < MAX_DISKS; j++) begin
      par          = par ^ lane_i[j].data;
      lane_diff[j] = lane_i[j].differs;
    end
    diff_new = diff_q | lane_diff;
    mis_new  = ((par != ref_i) && (mis_q != MIS_MAX)) ? mis_q + MIS_W'(1) : mis_q;
  end

  always_comb begin
    diff_d    = diff_q;
    mis_d     = mis_q;
    blk_o.done = 1'b0;
    if ((diff_new & en_i) == '0) begin
      blk_o.cls = CLS_MIRROR;
    end else if (mis_new <= THRESH) begin
      blk_o.cls = CLS_PARITY;
    end else begin
      blk_o.cls = CLS_MISS;
    end
    if (col_i) begin
      if (end_i) begin
        blk_o.done = 1'b1;
        diff_d     = '0;
        mis_d      = '0;
      end else begin
        diff_d = diff_new;
        mis_d  = mis_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
      mis_q  <= '0;
    end else begin
      diff_q <= diff_d;
      mis_q  <= mis_d;
    end
  end

endmodule

// File: rtl/rlc_decide.sv
// ----------------------------------------------------------------------------
// rlc_decide
// Verdict sequencer: snapshot counters, form scaled products, then compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlc_decide (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [3:0]               n_eff_i,
  input  logic [17:0]              m_i,
  input  logic [17:0]              p_i,
  input  logic [17:0]              x_i,
  output rlc_pkg::dec_stat_t       stat_o,
  output logic [17:0]              m_o,
  output logic [17:0]              p_o,
  output logic [17:0]              x_o
);
  import rlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_CMP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   m_q, p_q, x_q;
  logic [DCNT_W-1:0]  n_q;
  logic [CNT_W:0]     xp_sum, xm_sum, mp_sum;
  logic [CNT_W:0]     a1_q, a2_q;
  logic [CNT_W+2:0]   b1_q, b2_q, f_q;
  logic [CNT_W+K_W-1:0] kx_q;
  logic [CNT_W+10:0]  e_q;
  logic               n3_q;
  verdict_e           verdict;

  assign xp_sum = {1'b0, x_q} + {1'b0, p_q};
  assign xm_sum = {1'b0, x_q} + {1'b0, m_q};
  assign mp_sum = {1'b0, m_q} + {1'b0, p_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= m_i;
      p_q <= p_i;
      x_q <= x_i;
      n_q <= n_eff_i;
    end
    if (state_q == ST_MUL) begin
      a1_q <= {m_q, 1'b0};
      b1_q <= (CNT_W+3)'(xp_sum) * (CNT_W+3)'(3);
      a2_q <= {p_q, 1'b0};
      b2_q <= (CNT_W+3)'(xm_sum) * (CNT_W+3)'(3);
      kx_q <= (CNT_W+K_W)'(x_q) * (CNT_W+K_W)'(k_factor(n_q));
      e_q  <= (CNT_W+11)'(mp_sum) * (CNT_W+11)'(1000);
      f_q  <= (CNT_W+3)'(x_q) * (CNT_W+3)'(7);
      n3_q <= n_q >= DCNT_W'(3);
    end
  end

  always_comb begin
    if ({2'b00, a1_q} > b1_q) begin
      verdict = VRD_RAID1;
    end else if (({2'b00, a2_q} > b2_q) && n3_q) begin
      verdict = VRD_RAID5_FULL;
    end else if (((CNT_W+K_W)'(m_q) < kx_q) && (e_q > (CNT_W+11)'(f_q))) begin
      verdict = VRD_RAID5_PART;
    end else if ((CNT_W+K_W)'(m_q) > kx_q) begin
      verdict = VRD_RAID1;
    end else begin
      verdict = VRD_RAID0;
    end
  end

  assign stat_o.busy    = (state_q != ST_IDLE);
  assign stat_o.done    = (state_q == ST_CMP);
  assign stat_o.verdict = verdict;
  assign m_o = m_q;
  assign p_o = p_q;
  assign x_o = x_q;

  `RLC_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> state_q == ST_IDLE)
  `RLC_ASSERT(a_mul_to_cmp, clk_i, rst_ni, state_q == ST_MUL |=> state_q == ST_CMP)
  `RLC_ASSERT(a_done_once, clk_i, rst_ni, stat_o.done |=> !stat_o.done)

endmodule

// File: rtl/raid_level_classifier.sv
// A block_end column transfer gives its classification in the cycle after it.
// A decide transfer gives its verdict through the snapshot and product stages
//   and the compare state of the verdict sequencer, then the output register.
// Throughput: one column per cycle; a held result or busy decide stalls input.
// Reset: counters and block state clear, disk_count returns to 2, no result.
// ----------------------------------------------------------------------------
// raid_level_classifier
// Per-disk compare lanes, a merge stage for block classes, and a verdict unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module raid_level_classifier #(
  parameter int MAX_DISKS   = rlc_pkg::MAX_DISKS_DEF,
  parameter int BLOCK_BYTES = rlc_pkg::BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  rlc_col_if.sink    col_i,
  rlc_res_if.source  res_o
);
  import rlc_pkg::*;

  logic [DCNT_W-1:0]    dcnt_q, n_eff;
  logic [BYTE_W-1:0]    bytes [MAX_DISKS];
  logic [MAX_DISKS-1:1] lane_en;
  lane_res_t            lane_res [MAX_DISKS-1:1];
  blk_stat_t            blk;
  dec_stat_t            dec;
  logic [CNT_W-1:0]     dm, dp, dx;
  logic [CNT_W-1:0]     mir_q, mir_d, par_q, par_d, mis_q, mis_d;
  logic                 col_fire, col_go, dec_go, out_rdy;
  logic                 out_vld_q, out_load;
  result_kind_e         kind_q;
  block_class_e         cls_q;
  verdict_e             vrd_q;
  logic [CNT_W-1:0]     tm_q, tp_q, tx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= DCNT_RST;
    end else if (cfg_we_i) begin
      dcnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (dcnt_q < DCNT_MIN) begin
      n_eff = DCNT_MIN;
    end else if (dcnt_q > DCNT_W'(MAX_DISKS)) begin
      n_eff = DCNT_W'(MAX_DISKS);
    end else begin
      n_eff = dcnt_q;
    end
  end

  always_comb begin
    bytes[0] = col_i.disk0_byte;
    bytes[1] = col_i.disk1_byte;
    if (MAX_DISKS > 2) bytes[2 % MAX_DISKS] = col_i.disk2_byte;
    if (MAX_DISKS > 3) bytes[3 % MAX_DISKS] = col_i.disk3_byte;
    if (MAX_DISKS > 4) bytes[4 % MAX_DISKS] = col_i.disk4_byte;
    if (MAX_DISKS > 5) bytes[5 % MAX_DISKS] = col_i.disk5_byte;
    if (MAX_DISKS > 6) bytes[6 % MAX_DISKS] = col_i.disk6_byte;
    if (MAX_DISKS > 7) bytes[7 % MAX_DISKS] = col_i.disk7_byte;
  end

  assign out_rdy     = res_o.ready;
  assign col_i.ready = !dec.busy && (!out_vld_q || out_rdy);
  assign col_fire    = col_i.valid && col_i.ready;
  assign col_go      = col_fire && (col_i.op == OP_COLUMN);
  assign dec_go      = col_fire && (col_i.op == OP_DECIDE);

  for (genvar j = 1; j < MAX_DISKS; j++) begin : g_lane
    assign lane_en[j] = DCNT_W'(j) < n_eff;
    rlc_lane u_lane (
      .ref_i  (bytes[0]),
      .data_i (bytes[j]),
      .en_i   (lane_en[j]),
      .res_o  (lane_res[j])
    );
  end

  rlc_merge #(
    .MAX_DISKS   (MAX_DISKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .col_i  (col_go),
    .end_i  (col_i.block_end),
    .ref_i  (col_i.disk0_byte),
    .en_i   (lane_en),
    .lane_i (lane_res),
    .blk_o  (blk)
  );

  rlc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dec_go),
    .n_eff_i (n_eff),
    .m_i     (mir_q),
    .p_i     (par_q),
    .x_i     (mis_q),
    .stat_o  (dec),
    .m_o     (dm),
    .p_o     (dp),
    .x_o     (dx)
  );

  always_comb begin
    mir_d = mir_q;
    par_d = par_q;
    mis_d = mis_q;
    if (dec_go) begin
      mir_d = '0;
      par_d = '0;
      mis_d = '0;
    end else if (blk.done) begin
      case (blk.cls)
        CLS_MIRROR: mir_d = sat_inc(mir_q);
        CLS_PARITY: par_d = sat_inc(par_q);
        default:    mis_d = sat_inc(mis_q);
      endcase
    end
  end

  assign out_load = blk.done || dec.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mir_q     <= '0;
      par_q     <= '0;
      mis_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mir_q <= mir_d;
      par_q <= par_d;
      mis_q <= mis_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk.done) begin
      kind_q <= KIND_BLOCK;
      cls_q  <= blk.cls;
      vrd_q  <= VRD_RAID0;
      tm_q   <= mir_d;
      tp_q   <= par_d;
      tx_q   <= mis_d;
    end else if (dec.done) begin
      kind_q <= KIND_VERDICT;
      cls_q  <= CLS_MIRROR;
      vrd_q  <= dec.verdict;
      tm_q   <= dm;
      tp_q   <= dp;
      tx_q   <= dx;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.result_kind  = kind_q;
  assign res_o.block_class  = cls_q;
  assign res_o.verdict      = vrd_q;
  assign res_o.mirror_total = tm_q;
  assign res_o.parity_total = tp_q;
  assign res_o.miss_total   = tx_q;

  `RLC_ASSERT(a_load_free, clk_i, rst_ni, out_load |-> (!out_vld_q || out_rdy))
  `RLC_ASSERT(a_busy_stall, clk_i, rst_ni, dec.busy |-> !col_i.ready)
  `RLC_ASSERT(a_dec_clears, clk_i, rst_ni, dec_go |=> (mir_q == '0 && par_q == '0 && mis_q == '0))

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams byte columns and decide commands into raid_level_classifier under
// several flow-control patterns and disk counts. Every result transfer is
// checked field by field against an in-bench prediction of block classes,
// saturating class counters and RAID verdicts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlc_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int MIS_LIMIT   = BLOCK_BYTES_DEF / 100;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    op_e             op;
    logic [7:0][7:0] disk;
    logic            block_end;
  } column_t;

  typedef struct packed {
    result_kind_e     kind;
    block_class_e     cls;
    verdict_e         verdict;
    logic [CNT_W-1:0] mirrors;
    logic [CNT_W-1:0] parities;
    logic [CNT_W-1:0] misses;
  } summary_t;

  typedef enum int {BK_MIRROR, BK_PARITY, BK_MISS} block_kind_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [DCNT_W-1:0] cfg_wdata_i;

  rlc_col_if col ();
  rlc_res_if res ();

  raid_level_classifier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .col_i       (col),
    .res_o       (res)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predicted block state and counters
  logic [DCNT_W-1:0] disks_reg;
  logic [7:0]        differ_mask;
  logic [MIS_W-1:0]  parity_misses;
  logic [CNT_W-1:0]  mirror_cnt;
  logic [CNT_W-1:0]  parity_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  summary_t    summaries_due[$];
  column_t     columns_waiting[$];
  column_t     offer;
  bit          offering = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;
  int unsigned pushed = 0;

  function automatic int unsigned active_disks(input logic [DCNT_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DISKS_DEF) return MAX_DISKS_DEF;
    return v;
  endfunction

  function automatic verdict_e judge(input int unsigned n);
    longint unsigned m, p, x, k;
    m = mirror_cnt;
    p = parity_cnt;
    x = miss_cnt;
    k = 100 / (n + 1);
    if (2 * m > 3 * (x + p)) return VRD_RAID1;
    if (2 * p > 3 * (x + m) && n >= 3) return VRD_RAID5_FULL;
    if (m < k * x && 1000 * (m + p) > 7 * x) return VRD_RAID5_PART;
    if (m > k * x) return VRD_RAID1;
    return VRD_RAID0;
  endfunction

  task automatic classify_column(input column_t c);
    int unsigned n;
    logic [7:0]  acc;
    logic [7:0]  mask;
    summary_t    s;
    n = active_disks(disks_reg);
    s = '0;
    if (c.op == OP_DECIDE) begin
      s.kind = KIND_VERDICT;
      s.cls = CLS_MIRROR;
      s.verdict = judge(n);
      s.mirrors = mirror_cnt;
      s.parities = parity_cnt;
      s.misses = miss_cnt;
      summaries_due = {summaries_due, s};
      mirror_cnt = '0;
      parity_cnt = '0;
      miss_cnt = '0;
      return;
    end
    acc = '0;
    for (int j = 1; j < n; j++) begin
      if (c.disk[j] != c.disk[0]) differ_mask[j] = 1'b1;
      acc ^= c.disk[j];
    end
    if (acc != c.disk[0] && parity_misses != MIS_MAX) parity_misses++;
    if (!c.block_end) return;
    mask = 8'((1 << n) - 1) & 8'hFE;
    s.kind = KIND_BLOCK;
    s.verdict = VRD_RAID0;
    if ((differ_mask & mask) == '0) begin
      s.cls = CLS_MIRROR;
      if (mirror_cnt != CNT_MAX) mirror_cnt++;
    end else if (parity_misses <= MIS_LIMIT) begin
      s.cls = CLS_PARITY;
      if (parity_cnt != CNT_MAX) parity_cnt++;
    end else begin
      s.cls = CLS_MISS;
      if (miss_cnt != CNT_MAX) miss_cnt++;
    end
    differ_mask = '0;
    parity_misses = '0;
    s.mirrors = mirror_cnt;
    s.parities = parity_cnt;
    s.misses = miss_cnt;
    summaries_due = {summaries_due, s};
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
  endtask

  task automatic check_summary();
    summary_t want, got;
    got = summary_t'({res.result_kind, res.block_class, res.verdict,
                      res.mirror_total, res.parity_total, res.miss_total});
    if (summaries_due.size() == 0) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
      return;
    end
    want = summaries_due.pop_front();
    if (got.kind !== want.kind) report("result_kind", want.kind, got.kind);
    if (got.cls !== want.cls) report("block_class", want.cls, got.cls);
    if (got.verdict !== want.verdict) report("verdict", want.verdict, got.verdict);
    if (got.mirrors !== want.mirrors) report("mirror_total", want.mirrors, got.mirrors);
    if (got.parities !== want.parities) report("parity_total", want.parities, got.parities);
    if (got.misses !== want.misses) report("miss_total", want.misses, got.misses);
  endtask

  // column source
  always @(posedge clk_i) begin
    if (rst_ni && col.valid && col.ready) begin
      classify_column(offer);
      offering = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!offering && columns_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      offer = columns_waiting.pop_front();
      offering = 1'b1;
      col.op <= offer.op;
      col.disk0_byte <= offer.disk[0];
      col.disk1_byte <= offer.disk[1];
      col.disk2_byte <= offer.disk[2];
      col.disk3_byte <= offer.disk[3];
      col.disk4_byte <= offer.disk[4];
      col.disk5_byte <= offer.disk[5];
      col.disk6_byte <= offer.disk[6];
      col.disk7_byte <= offer.disk[7];
      col.block_end <= offer.block_end;
    end
    col.valid <= offering;
  end

  // result sink
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) check_summary();
  end

  always @(negedge clk_i) begin
    res.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left--;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic column_t make_column(input op_e op, input logic [7:0] d0,
                                          input logic [7:0] d1, input logic [7:0] rest,
                                          input logic last);
    column_t c;
    c.op = op;
    c.disk = {{6{rest}}, d1, d0};
    c.block_end = last;
    return c;
  endfunction

  function automatic column_t rand_column();
    column_t c;
    c.op = OP_COLUMN;
    for (int j = 0; j < 8; j++) c.disk[j] = 8'($urandom);
    c.block_end = 1'b0;
    return c;
  endfunction

  task automatic push_column(input column_t c);
    columns_waiting = {columns_waiting, c};
    pushed++;
  endtask

  task automatic push_decide();
    column_t c;
    c = rand_column();
    c.op = OP_DECIDE;
    c.block_end = 1'($urandom_range(0, 1));
    push_column(c);
  endtask

  // bad: columns whose disk 0 breaks parity in a parity block
  task automatic push_block(input block_kind_e kind, input int len, input int bad);
    column_t     c;
    logic [7:0]  acc;
    int unsigned n;
    n = active_disks(disks_reg);
    for (int i = 0; i < len; i++) begin
      c = rand_column();
      if (kind == BK_MIRROR) begin
        for (int j = 1; j < n; j++) c.disk[j] = c.disk[0];
      end else if (kind == BK_PARITY) begin
        acc = '0;
        for (int j = 1; j < n; j++) acc ^= c.disk[j];
        c.disk[0] = (i < bad) ? acc ^ 8'($urandom_range(1, 255)) : acc;
      end
      c.block_end = (i == len - 1);
      push_column(c);
      if ($urandom_range(0, 99) < 4) push_decide();
    end
  endtask

  task automatic run_round();
    int unsigned blocks, bias, r;
    block_kind_e kind;
    column_t     c;
    blocks = $urandom_range(0, 8);
    bias = $urandom_range(0, 3);
    for (int b = 0; b < blocks; b++) begin
      r = $urandom_range(0, 99);
      case (bias)
        0: kind = (r < 75) ? BK_MIRROR : (r < 90) ? BK_PARITY : BK_MISS;
        1: kind = (r < 75) ? BK_PARITY : (r < 90) ? BK_MIRROR : BK_MISS;
        2: kind = (r < 75) ? BK_MISS : (r < 90) ? BK_PARITY : BK_MIRROR;
        default: kind = (r < 33) ? BK_MIRROR : (r < 66) ? BK_PARITY : BK_MISS;
      endcase
      push_block(kind, $urandom_range(1, 10), $urandom_range(0, 7));
      if ($urandom_range(0, 99) < 5) begin
        c = rand_column();
        c.block_end = 1'($urandom_range(0, 1));
        push_column(c);
      end
    end
    push_decide();
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (columns_waiting.size() != 0 || offering || summaries_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_disks(input logic [DCNT_W-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    disks_reg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  logic [DCNT_W-1:0] phase_disks[8] = '{4'd8, 4'd3, 4'd2, 4'd5, 4'd15, 4'd6, 4'd0, 4'd7};

  initial begin
    column_t c;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    col.valid = 1'b0;
    col.op = OP_COLUMN;
    col.disk0_byte = '0;
    col.disk1_byte = '0;
    col.disk2_byte = '0;
    col.disk3_byte = '0;
    col.disk4_byte = '0;
    col.disk5_byte = '0;
    col.disk6_byte = '0;
    col.disk7_byte = '0;
    col.block_end = 1'b0;
    res.ready = 1'b0;
    disks_reg = DCNT_RST;
    differ_mask = '0;
    parity_misses = '0;
    mirror_cnt = '0;
    parity_cnt = '0;
    miss_cnt = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // two disks out of reset
    push_column(make_column(OP_DECIDE, 8'h00, 8'h00, 8'h00, 1'b0));
    push_column(make_column(OP_COLUMN, 8'h00, 8'h00, 8'hFF, 1'b1));
    push_column(make_column(OP_COLUMN, 8'hFF, 8'hFF, 8'h00, 1'b1));
    push_column(make_column(OP_COLUMN, 8'hFF, 8'h00, 8'hFF, 1'b1));
    push_column(make_column(OP_COLUMN, 8'h55, 8'hAA, 8'h55, 1'b0));
    push_column(make_column(OP_DECIDE, 8'hFF, 8'h00, 8'hFF, 1'b1));
    push_column(make_column(OP_COLUMN, 8'hAA, 8'hAA, 8'hAA, 1'b1));
    for (int i = 0; i < 6; i++)
      push_column(make_column(OP_COLUMN, 8'h01 << i, 8'h00, 8'h00, i == 5));
    push_decide();
    // parity-only history with two disks cannot be complete raid5
    for (int i = 0; i < 3; i++)
      push_column(make_column(OP_COLUMN, 8'hFF, 8'h00, 8'h00, 1'b1));
    push_decide();

    write_disks(4'd3);
    for (int i = 0; i < 3; i++)
      push_column(make_column(OP_COLUMN, 8'hFF, 8'h00, 8'h00, 1'b1));
    push_decide();

    write_disks(4'd8);
    c = make_column(OP_COLUMN, 8'hFF, 8'h0F, 8'h00, 1'b1);
    c.disk[2] = 8'hF0;
    push_column(c);
    c = make_column(OP_COLUMN, 8'h00, 8'h00, 8'h00, 1'b1);
    c.disk[7] = 8'h80;
    push_column(c);
    push_decide();

    // out-of-range disk counts clamp
    write_disks(4'd0);
    push_column(c);
    write_disks(4'd1);
    push_column(c);
    write_disks(4'd9);
    push_column(c);
    write_disks(4'd15);
    push_column(c);
    push_decide();

    // long blocks: threshold stays fixed, not scaled with block length
    push_block(BK_MISS, 40, 0);
    push_decide();
    write_disks(4'd3);
    push_block(BK_PARITY, 30, 5);
    push_block(BK_PARITY, 30, 6);
    push_decide();

    for (int ph = 0; ph < 8; ph++) begin
      write_disks(phase_disks[ph]);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 66; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      if (ph == 4) hold_left = HOLD_CYCLES;
      pushed = 0;
      while (pushed < PHASE_ITEMS) run_round();
    end

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rlc_pkg.sv
rtl/rlc_if.sv
rtl/rlc_lane.sv
rtl/rlc_merge.sv
rtl/rlc_decide.sv
rtl/raid_level_classifier.sv
test/testbench.sv
